// ===== src/duplicate_entry_merge_defines.svh =====
// Shared assertion macros for the duplicate entry merge block.
`ifndef DUPLICATE_ENTRY_MERGE_DEFINES_SVH
`define DUPLICATE_ENTRY_MERGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DEDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("duplicate_entry_merge: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define DEDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("duplicate_entry_merge: next-cycle check failed");

`endif

// ===== src/dedm_pkg.sv =====
package dedm_pkg;

    localparam int IDX_W     = 32;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 48;
    localparam int CNT_W     = 16;
    localparam int POL_W     = 3;
    localparam int DIV_CNT_W = $clog2(ACC_W);

    typedef logic        [IDX_W-1:0] t_idx;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic        [CNT_W-1:0] t_cnt;
    typedef logic        [POL_W-1:0] t_pol;

    localparam t_pol POL_SUM  = 3'd0;
    localparam t_pol POL_AVG  = 3'd1;
    localparam t_pol POL_MAX  = 3'd2;
    localparam t_pol POL_MIN  = 3'd3;
    localparam t_pol POL_LAST = 3'd4;

    localparam t_cnt CNT_MAX = '1;
    localparam t_cnt CNT_ONE = t_cnt'(1);

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam t_val OUT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val OUT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam t_acc ACC_OUT_MAX = t_acc'(OUT_MAX);
    localparam t_acc ACC_OUT_MIN = t_acc'(OUT_MIN);

    typedef struct packed {
        logic capture;
        logic fold;
        logic load_new;
        logic snap_old;
        logic snap_last;
        logic calc_start;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic pend_valid;
        logic in_eos;
        logic snap_last;
        logic calc_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/dedm_if.sv =====
interface dedm_entry_if;
    logic              valid;
    logic              ready;
    dedm_pkg::t_idx    entry_row;
    dedm_pkg::t_idx    entry_col;
    dedm_pkg::t_val    entry_value;
    logic              end_of_stream;

    modport source (output valid, output entry_row, output entry_col,
                    output entry_value, output end_of_stream, input ready);
    modport sink   (input valid, input entry_row, input entry_col,
                    input entry_value, input end_of_stream, output ready);
endinterface

interface dedm_result_if;
    logic              valid;
    logic              ready;
    dedm_pkg::t_idx    out_row;
    dedm_pkg::t_idx    out_col;
    dedm_pkg::t_val    out_value;
    logic              out_last;

    modport source (output valid, output out_row, output out_col,
                    output out_value, output out_last, input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input out_value, input out_last, output ready);
endinterface

interface dedm_cfg_if;
    logic              valid;
    logic              ready;
    dedm_pkg::t_pol    collision_policy;

    modport source (output valid, output collision_policy, input ready);
    modport sink   (input valid, input collision_policy, output ready);
endinterface

// ===== src/duplicate_entry_merge.sv =====
// Merges runs of equal (row, column) sparse matrix entries from a stream
// sorted by row, then column. Entries arrive on i_entry (valid/ready); merged
// entries leave on o_result (valid/ready). i_cfg writes collision_policy
// (0 sum, 1 average, 2 max, 3 min, 4 last; other codes sum) and is always
// ready; write it only while the block is idle.
// One entry is worked on at a time. An entry either folds into the run or
// starts a new one and emits the old run's result; end_of_stream also
// flushes the pending run.
// Under the average policy with a run longer than one, the sum is divided by
// the run count in a restoring divider that yields all 48 quotient bits, and
// the quotient is then handed over to the output.
// The output register holds a result while the receiver stalls; the block
// takes the next entry meanwhile and waits only when it has another result
// to place. end_of_stream flushes the pending entry with out_last set.
// Synchronous reset clears the pending entry, the policy (to sum) and the
// output valid.
module duplicate_entry_merge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dedm_cfg_if.sink    i_cfg,
    dedm_entry_if.sink  i_entry,
    dedm_result_if.source o_result
);

    dedm_pkg::t_dp_cmd w_cmd;
    dedm_pkg::t_dp_sts w_sts;
    logic              w_in_ready;

    assign i_cfg.ready   = 1'b1;
    assign i_entry.ready = w_in_ready;

    dedm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_entry.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dedm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry_row     (i_entry.entry_row),
        .i_entry_col     (i_entry.entry_col),
        .i_entry_value   (i_entry.entry_value),
        .i_end_of_stream (i_entry.end_of_stream),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_policy    (i_cfg.collision_policy),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_result.valid),
        .i_out_ready     (o_result.ready),
        .o_out_row       (o_result.out_row),
        .o_out_col       (o_result.out_col),
        .o_out_value     (o_result.out_value),
        .o_out_last      (o_result.out_last)
    );

endmodule

// ===== src/dedm_div.sv =====
module dedm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dedm_pkg::ACC_W-1:0]  i_dividend,
    input  dedm_pkg::t_cnt              i_divisor,
    output logic                        o_done,
    output logic [dedm_pkg::ACC_W-1:0]  o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [dedm_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [dedm_pkg::CNT_W-1:0]        r_rem;
    logic [dedm_pkg::ACC_W-1:0]        r_quo;
    dedm_pkg::t_cnt                    r_dsr;

    logic [dedm_pkg::CNT_W:0]          w_shift;
    logic [dedm_pkg::CNT_W:0]          w_diff;
    logic                              w_ge;

    // one quotient bit per cycle, restoring form
    assign w_shift = {r_rem, r_quo[dedm_pkg::ACC_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dedm_pkg::DIV_CNT_W'(dedm_pkg::ACC_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[dedm_pkg::CNT_W-1:0] : w_shift[dedm_pkg::CNT_W-1:0];
            r_quo <= {r_quo[dedm_pkg::ACC_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== src/dedm_dp.sv =====
`include "duplicate_entry_merge_defines.svh"

module dedm_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dedm_pkg::t_idx    i_entry_row,
    input  dedm_pkg::t_idx    i_entry_col,
    input  dedm_pkg::t_val    i_entry_value,
    input  logic              i_end_of_stream,
    input  logic              i_cfg_we,
    input  dedm_pkg::t_pol    i_cfg_policy,
    input  dedm_pkg::t_dp_cmd i_cmd,
    output dedm_pkg::t_dp_sts o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dedm_pkg::t_idx    o_out_row,
    output dedm_pkg::t_idx    o_out_col,
    output dedm_pkg::t_val    o_out_value,
    output logic              o_out_last
);

    dedm_pkg::t_pol r_policy;

    // captured input beat
    dedm_pkg::t_idx r_in_row;
    dedm_pkg::t_idx r_in_col;
    dedm_pkg::t_val r_in_val;
    logic           r_in_eos;

    // pending entry
    logic           r_pend_valid;
    dedm_pkg::t_idx r_pend_row;
    dedm_pkg::t_idx r_pend_col;
    dedm_pkg::t_acc r_pend_acc;
    dedm_pkg::t_cnt r_pend_cnt;

    // entry on its way out
    dedm_pkg::t_idx r_snap_row;
    dedm_pkg::t_idx r_snap_col;
    dedm_pkg::t_acc r_snap_acc;
    dedm_pkg::t_cnt r_snap_cnt;
    logic           r_snap_last;

    dedm_pkg::t_acc r_res;
    logic           r_res_neg;
    logic           r_calc_done;

    logic           r_out_valid;
    dedm_pkg::t_idx r_out_row;
    dedm_pkg::t_idx r_out_col;
    dedm_pkg::t_val r_out_val;
    logic           r_out_last;

    dedm_pkg::t_acc              w_val_ext;
    logic signed [dedm_pkg::ACC_W:0] w_sum;
    dedm_pkg::t_acc              w_sum_sat;
    dedm_pkg::t_acc              n_acc;
    logic                        w_need_div;
    logic                        w_acc_neg;
    logic [dedm_pkg::ACC_W-1:0]  w_acc_mag;
    logic                        w_div_done;
    logic [dedm_pkg::ACC_W-1:0]  w_quot;
    dedm_pkg::t_val              w_clamp;
    logic                        w_out_free;

    assign w_val_ext = dedm_pkg::t_acc'(r_in_val);
    assign w_sum     = {r_pend_acc[dedm_pkg::ACC_W-1], r_pend_acc}
                     + {w_val_ext[dedm_pkg::ACC_W-1], w_val_ext};

    always_comb begin
        if (w_sum[dedm_pkg::ACC_W] != w_sum[dedm_pkg::ACC_W-1]) begin
            w_sum_sat = w_sum[dedm_pkg::ACC_W] ? dedm_pkg::ACC_MIN : dedm_pkg::ACC_MAX;
        end else begin
            w_sum_sat = w_sum[dedm_pkg::ACC_W-1:0];
        end
    end

    always_comb begin
        case (r_policy)
            dedm_pkg::POL_MAX:  n_acc = (w_val_ext > r_pend_acc) ? w_val_ext : r_pend_acc;
            dedm_pkg::POL_MIN:  n_acc = (w_val_ext < r_pend_acc) ? w_val_ext : r_pend_acc;
            dedm_pkg::POL_LAST: n_acc = w_val_ext;
            default:            n_acc = w_sum_sat;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= dedm_pkg::POL_SUM;
        end else if (i_cfg_we) begin
            r_policy <= i_cfg_policy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_row <= i_entry_row;
            r_in_col <= i_entry_col;
            r_in_val <= i_entry_value;
            r_in_eos <= i_end_of_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_row   <= '0;
            r_pend_col   <= '0;
            r_pend_acc   <= '0;
            r_pend_cnt   <= '0;
        end else begin
            if (i_cmd.fold) begin
                r_pend_acc <= n_acc;
                if (r_pend_cnt != dedm_pkg::CNT_MAX) begin
                    r_pend_cnt <= r_pend_cnt + 1'b1;
                end
            end else if (i_cmd.load_new) begin
                r_pend_valid <= 1'b1;
                r_pend_row   <= r_in_row;
                r_pend_col   <= r_in_col;
                r_pend_acc   <= w_val_ext;
                r_pend_cnt   <= dedm_pkg::CNT_ONE;
            end else if (i_cmd.snap_last) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // snapshot takes the pending entry as it stands before this edge
    always_ff @(posedge i_clk) begin
        if (i_cmd.snap_old || i_cmd.snap_last) begin
            r_snap_row  <= r_pend_row;
            r_snap_col  <= r_pend_col;
            r_snap_acc  <= r_pend_acc;
            r_snap_cnt  <= r_pend_cnt;
            r_snap_last <= i_cmd.snap_last;
        end
    end

    assign w_need_div = (r_policy == dedm_pkg::POL_AVG) && (r_snap_cnt > dedm_pkg::CNT_ONE);
    assign w_acc_neg  = r_snap_acc[dedm_pkg::ACC_W-1];
    assign w_acc_mag  = w_acc_neg ? (~r_snap_acc + 1'b1) : r_snap_acc;

    dedm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.calc_start && w_need_div),
        .i_dividend (w_acc_mag),
        .i_divisor  (r_snap_cnt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calc_done <= 1'b0;
        end else if (i_cmd.calc_start) begin
            r_calc_done <= !w_need_div;
        end else if (w_div_done) begin
            r_calc_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_start) begin
            r_res     <= r_snap_acc;
            r_res_neg <= w_acc_neg;
        end else if (w_div_done) begin
            r_res <= r_res_neg ? dedm_pkg::t_acc'(~w_quot + 1'b1) : dedm_pkg::t_acc'(w_quot);
        end
    end

    always_comb begin
        if (r_res > dedm_pkg::ACC_OUT_MAX) begin
            w_clamp = dedm_pkg::OUT_MAX;
        end else if (r_res < dedm_pkg::ACC_OUT_MIN) begin
            w_clamp = dedm_pkg::OUT_MIN;
        end else begin
            w_clamp = r_res[dedm_pkg::VAL_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row  <= r_snap_row;
            r_out_col  <= r_snap_col;
            r_out_val  <= w_clamp;
            r_out_last <= r_snap_last;
        end
    end

    assign o_sts.match      = r_pend_valid && (r_pend_row == r_in_row)
                              && (r_pend_col == r_in_col);
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.in_eos     = r_in_eos;
    assign o_sts.snap_last  = r_snap_last;
    assign o_sts.calc_done  = r_calc_done;
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_val;
    assign o_out_last  = r_out_last;

    `DEDM_ASSERT_NOW(a_fold_on_match, i_clk, i_rst_n, i_cmd.fold, o_sts.match)
    `DEDM_ASSERT_NEXT(a_last_clears_pend, i_clk, i_rst_n, i_cmd.snap_last,
        !r_pend_valid && r_snap_last)
    `DEDM_ASSERT_NOW(a_load_needs_room, i_clk, i_rst_n, i_cmd.out_load,
        w_out_free && r_calc_done)

endmodule

// ===== src/dedm_ctrl.sv =====
`include "duplicate_entry_merge_defines.svh"

module dedm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dedm_pkg::t_dp_sts i_sts,
    output dedm_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SNAPL = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.match) begin
                    o_cmd.fold = 1'b1;
                    n_state    = i_sts.in_eos ? S_SNAPL : S_IDLE;
                end else begin
                    // new run: old pending entry goes out first
                    o_cmd.load_new = 1'b1;
                    if (i_sts.pend_valid) begin
                        o_cmd.snap_old = 1'b1;
                        n_state        = S_CALC;
                    end else begin
                        n_state = i_sts.in_eos ? S_SNAPL : S_IDLE;
                    end
                end
            end
            S_SNAPL: begin
                o_cmd.snap_last = 1'b1;
                n_state         = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc_start = 1'b1;
                n_state          = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.calc_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = (!i_sts.snap_last && i_sts.in_eos) ? S_SNAPL : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `DEDM_ASSERT_NEXT(a_accept_to_eval, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == S_EVAL)
    `DEDM_ASSERT_NEXT(a_wait_holds, i_clk, i_rst_n, r_state == S_WAIT && !i_sts.calc_done,
        r_state == S_WAIT)

endmodule

// ===== test/tb_duplicate_entry_merge.sv =====
`timescale 1ns / 1ps

module tb_duplicate_entry_merge;

    localparam int   CYCLE_LIMIT = 2_000_000;
    localparam int   IDLE_GUARD  = 80;
    localparam int   REPORT_CAP  = 10;
    localparam int   RANDOM_ITEMS = 1400;
    localparam dedm_pkg::t_pol POL_RSVD5 = 3'd5;
    localparam dedm_pkg::t_pol POL_RSVD7 = 3'd7;

    typedef struct {
        dedm_pkg::t_idx row;
        dedm_pkg::t_idx col;
        dedm_pkg::t_val value;
        logic           eos;
    } t_entry;

    typedef struct {
        dedm_pkg::t_idx row;
        dedm_pkg::t_idx col;
        dedm_pkg::t_val value;
        logic           last;
    } t_merged;

    logic i_clk;
    logic i_rst_n;

    dedm_cfg_if    cfg ();
    dedm_entry_if  ent ();
    dedm_result_if res ();

    duplicate_entry_merge dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_entry  (ent),
        .o_result (res)
    );

    t_entry  entry_feed[$];
    t_merged merged_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    // Run tracker: mirrors the pending entry held by the block.
    dedm_pkg::t_pol model_policy = dedm_pkg::POL_SUM;
    logic           run_open     = 1'b0;
    dedm_pkg::t_idx run_row      = '0;
    dedm_pkg::t_idx run_col      = '0;
    dedm_pkg::t_acc run_accum    = '0;
    dedm_pkg::t_cnt run_count    = '0;

    always #4 i_clk = ~i_clk;

    function automatic dedm_pkg::t_val merged_value();
        longint v;
        v = longint'(run_accum);
        if (model_policy == dedm_pkg::POL_AVG && run_count > dedm_pkg::CNT_ONE) begin
            v = v / longint'(run_count);
        end
        if (v > longint'(dedm_pkg::OUT_MAX)) begin
            v = longint'(dedm_pkg::OUT_MAX);
        end else if (v < longint'(dedm_pkg::OUT_MIN)) begin
            v = longint'(dedm_pkg::OUT_MIN);
        end
        return dedm_pkg::t_val'(v);
    endfunction

    task automatic merge_entry(input dedm_pkg::t_idx row, input dedm_pkg::t_idx col,
                               input dedm_pkg::t_val value, input logic eos);
        longint total;
        if (run_open && run_row == row && run_col == col) begin
            case (model_policy)
                dedm_pkg::POL_MAX: begin
                    if (value > run_accum) run_accum = value;
                end
                dedm_pkg::POL_MIN: begin
                    if (value < run_accum) run_accum = value;
                end
                dedm_pkg::POL_LAST: begin
                    run_accum = value;
                end
                default: begin
                    total = longint'(run_accum) + longint'(value);
                    if (total > longint'(dedm_pkg::ACC_MAX)) begin
                        run_accum = dedm_pkg::ACC_MAX;
                    end else if (total < longint'(dedm_pkg::ACC_MIN)) begin
                        run_accum = dedm_pkg::ACC_MIN;
                    end else begin
                        run_accum = dedm_pkg::t_acc'(total);
                    end
                end
            endcase
            if (run_count != dedm_pkg::CNT_MAX) run_count = run_count + dedm_pkg::CNT_ONE;
        end else begin
            if (run_open) merged_q.push_back('{run_row, run_col, merged_value(), 1'b0});
            run_open  = 1'b1;
            run_row   = row;
            run_col   = col;
            run_accum = value;
            run_count = dedm_pkg::CNT_ONE;
        end
        if (eos) begin
            merged_q.push_back('{run_row, run_col, merged_value(), 1'b1});
            run_open = 1'b0;
        end
    endtask

    // Entry driver: hold a beat until accepted, otherwise pull from the feed.
    always @(posedge i_clk) begin : drive_entries
        t_entry nxt;
        if (!i_rst_n) begin
            ent.valid <= 1'b0;
        end else begin
            if (ent.valid && ent.ready) begin
                merge_entry(ent.entry_row, ent.entry_col, ent.entry_value, ent.end_of_stream);
            end
            if (!ent.valid || ent.ready) begin
                if (entry_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = entry_feed.pop_front();
                    ent.entry_row     <= nxt.row;
                    ent.entry_col     <= nxt.col;
                    ent.entry_value   <= nxt.value;
                    ent.end_of_stream <= nxt.eos;
                    ent.valid         <= 1'b1;
                end else begin
                    ent.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each merged beat against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_merged want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (merged_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP) begin
                        $display("unexpected merged entry: row=%h col=%h value=%h last=%b",
                                 res.out_row, res.out_col, res.out_value, res.out_last);
                    end
                end else begin
                    want = merged_q.pop_front();
                    if (want.row !== res.out_row || want.col !== res.out_col ||
                        want.value !== res.out_value || want.last !== res.out_last) begin
                        fail_count++;
                        if (fail_count <= REPORT_CAP) begin
                            $display({"merged entry mismatch: expected row=%h col=%h ",
                                      "value=%h last=%b, got row=%h col=%h value=%h last=%b"},
                                     want.row, want.col, want.value, want.last,
                                     res.out_row, res.out_col, res.out_value, res.out_last);
                        end
                    end
                end
            end
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_duplicate_entry_merge failed");
            $finish;
        end
    end

    task automatic add_entry(input dedm_pkg::t_idx row, input dedm_pkg::t_idx col,
                             input dedm_pkg::t_val value, input logic eos);
        entry_feed.push_back('{row, col, value, eos});
    endtask

    // Wait for the block to drain, then give any fold or division time to finish.
    task automatic settle();
        while (entry_feed.size() != 0 || ent.valid || merged_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    task automatic reconfigure(input dedm_pkg::t_pol code);
        settle();
        cfg.valid            <= 1'b1;
        cfg.collision_policy <= code;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        model_policy = code;
        cfg.valid    <= 1'b0;
    endtask

    function automatic dedm_pkg::t_val pick_value();
        case ($urandom_range(5))
            0:       return dedm_pkg::OUT_MAX;
            1:       return dedm_pkg::OUT_MIN;
            2:       return dedm_pkg::t_val'($urandom_range(32'h0006_0000))
                            - dedm_pkg::t_val'(32'h0003_0000);
            3:       return dedm_pkg::t_val'(32'h7FF0_0000 + $urandom_range(32'h000F_FFFF));
            default: return dedm_pkg::t_val'($urandom);
        endcase
    endfunction

    // Sorted stream with random run lengths; a few jumps break the ordering.
    task automatic queue_sorted_stream(input int n_entries, input bit close_run);
        dedm_pkg::t_idx row;
        dedm_pkg::t_idx col;
        logic           eos;
        row = ($urandom_range(1) != 0) ? dedm_pkg::t_idx'($urandom)
                                       : dedm_pkg::t_idx'($urandom_range(15));
        col = ($urandom_range(1) != 0) ? dedm_pkg::t_idx'($urandom)
                                       : dedm_pkg::t_idx'($urandom_range(15));
        for (int i = 0; i < n_entries; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: ;
                4, 5, 6: col = col + dedm_pkg::t_idx'($urandom_range(1, 3));
                7: begin
                    row = row + 1'b1;
                    col = dedm_pkg::t_idx'($urandom_range(4));
                end
                8: col = dedm_pkg::t_idx'($urandom);
                default: begin
                    row = dedm_pkg::t_idx'($urandom);
                    col = dedm_pkg::t_idx'($urandom);
                end
            endcase
            eos = (close_run && i == n_entries - 1) || ($urandom_range(29) == 0);
            add_entry(row, col, pick_value(), eos);
        end
    endtask

    task automatic run_random_traffic(input int n_entries);
        int queued;
        int len;
        queued = 0;
        while (queued < n_entries) begin
            reconfigure(dedm_pkg::t_pol'($urandom_range(7)));
            repeat ($urandom_range(2, 5)) begin
                len = $urandom_range(5, 40);
                queue_sorted_stream(len, $urandom_range(3) != 0);
                queued += len;
            end
        end
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        cfg.valid            = 1'b0;
        cfg.collision_policy = dedm_pkg::POL_SUM;
        ent.valid            = 1'b0;
        ent.entry_row        = '0;
        ent.entry_col        = '0;
        ent.entry_value      = '0;
        ent.end_of_stream    = 1'b0;
        res.ready            = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 72;

        // Output clamps both ways; coordinate change plus flush in one beat.
        reconfigure(dedm_pkg::POL_SUM);
        add_entry(0, 0, dedm_pkg::OUT_MAX, 1'b0);
        add_entry(0, 0, dedm_pkg::OUT_MAX, 1'b0);
        add_entry(0, 1, dedm_pkg::OUT_MIN, 1'b0);
        add_entry(0, 1, dedm_pkg::OUT_MIN, 1'b1);
        add_entry('1, '1, dedm_pkg::t_val'(-1), 1'b1);

        // Average truncates toward zero; a lone entry is not divided.
        reconfigure(dedm_pkg::POL_AVG);
        add_entry(5, 7, dedm_pkg::t_val'(3), 1'b0);
        add_entry(5, 7, dedm_pkg::t_val'(-8), 1'b0);
        add_entry(5, 8, dedm_pkg::t_val'(32'h0001_2345), 1'b0);
        add_entry(6, 0, dedm_pkg::OUT_MIN, 1'b0);
        add_entry(6, 0, dedm_pkg::OUT_MAX, 1'b1);

        // Leave (7,2) open across a policy change.
        reconfigure(dedm_pkg::POL_MAX);
        add_entry(7, 1, dedm_pkg::t_val'(-5), 1'b0);
        add_entry(7, 1, dedm_pkg::t_val'(10), 1'b0);
        add_entry(7, 1, dedm_pkg::t_val'(3), 1'b0);
        add_entry(7, 2, dedm_pkg::t_val'(1), 1'b0);
        reconfigure(dedm_pkg::POL_MIN);
        add_entry(7, 2, dedm_pkg::t_val'(-9), 1'b0);
        add_entry(7, 2, dedm_pkg::t_val'(4), 1'b1);

        // Non-adjacent duplicates stay separate.
        reconfigure(dedm_pkg::POL_LAST);
        add_entry(1, 1, dedm_pkg::t_val'(5), 1'b0);
        add_entry(1, 2, dedm_pkg::t_val'(6), 1'b0);
        add_entry(1, 1, dedm_pkg::t_val'(7), 1'b0);
        add_entry(1, 1, dedm_pkg::t_val'(-3), 1'b1);

        reconfigure(POL_RSVD7);
        add_entry(2, 2, dedm_pkg::OUT_MAX, 1'b0);
        add_entry(2, 2, dedm_pkg::t_val'(1), 1'b1);

        run_random_traffic(RANDOM_ITEMS / 3);

        settle();
        send_idle_pct = 72;
        recv_idle_pct = 31;
        reconfigure(POL_RSVD5);
        run_random_traffic(RANDOM_ITEMS / 3);

        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(RANDOM_ITEMS / 3);

        settle();
        if (merged_q.size() != 0) begin
            fail_count += merged_q.size();
            $display("%0d merged entries never arrived", merged_q.size());
        end
        if (fail_count == 0) begin
            $display("tb_duplicate_entry_merge passed");
        end else begin
            $display("tb_duplicate_entry_merge failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/dedm_pkg.sv
src/dedm_if.sv
src/dedm_div.sv
src/dedm_dp.sv
src/dedm_ctrl.sv
src/duplicate_entry_merge.sv
test/tb_duplicate_entry_merge.sv
